FILE: hw/rtl/rpc_pkg.sv
// Shared types, widths and the soft-light root table of the pixel compositor.
`default_nettype none

package rpc_pkg;

    // Operator codes as carried in the blend_mode register.
    typedef enum logic [4:0] {
        MODE_COPY,
        MODE_SRC_OVER,
        MODE_SRC_IN,
        MODE_SRC_OUT,
        MODE_SRC_ATOP,
        MODE_DST_OVER,
        MODE_DST_IN,
        MODE_DST_OUT,
        MODE_DST_ATOP,
        MODE_LIGHTER,
        MODE_XOR,
        MODE_MULTIPLY,
        MODE_SCREEN,
        MODE_OVERLAY,
        MODE_DARKEN,
        MODE_LIGHTEN,
        MODE_COLOR_DODGE,
        MODE_COLOR_BURN,
        MODE_HARD_LIGHT,
        MODE_SOFT_LIGHT,
        MODE_DIFFERENCE,
        MODE_EXCLUSION
    } mode_t;

    // Numerator, denominator and running remainder widths of the divider.
    localparam int N_W = 43;
    localparam int Q_W = 32;
    localparam int R_W = 40;

    // One setup stage plus one stage per quotient bit.
    localparam int DIV_STAGES  = 9;
    localparam int DIV_FIRST   = 6;
    localparam int PIPE_STAGES = DIV_FIRST + DIV_STAGES;
    localparam int LANES       = 4;

    typedef logic [15:0] sqrt_lut_t [256];

    // Entry d holds floor(sqrt(d * 2^24)), built by a digit-by-digit root.
    function automatic sqrt_lut_t sqrt_lut_build();
        sqrt_lut_t lut;
        logic [31:0] x;
        logic [31:0] res;
        logic [31:0] bitv;
        for (int i = 0; i < 256; i++)
        begin
            x    = 32'(i) << 24;
            res  = '0;
            bitv = 32'h4000_0000;
            for (int j = 0; j < 16; j++)
            begin
                if (x >= res + bitv)
                begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            lut[i] = res[15:0];
        end
        return lut;
    endfunction

    localparam sqrt_lut_t SQRT_LUT = sqrt_lut_build();

endpackage

`default_nettype wire

FILE: hw/rtl/rpc_div.sv
// Pipelined saturating divider: floor(num / den) clamped to 255, one bit a stage.
`default_nettype none

module rpc_div (
    input  logic                              clk,
    input  logic [rpc_pkg::DIV_STAGES-1:0]    en,
    input  logic [rpc_pkg::N_W-1:0]           num,
    input  logic [rpc_pkg::Q_W-1:0]           den,
    output logic [7:0]                        quo
);

    localparam int LAST = rpc_pkg::DIV_STAGES - 1;

    logic [rpc_pkg::R_W-1:0] rem_reg [LAST];
    logic [rpc_pkg::Q_W-1:0] den_reg [LAST];
    logic [7:0]              q_reg   [rpc_pkg::DIV_STAGES];
    logic                    sat_reg [rpc_pkg::DIV_STAGES];

    // A quotient of 256 or more saturates, so the remainder then fits R_W bits.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sat_reg[0] <= num >= (rpc_pkg::N_W'(den) << 8);
            rem_reg[0] <= num[rpc_pkg::R_W-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
        end
    end

    for (genvar j = 1; j < rpc_pkg::DIV_STAGES; j++)
    begin : g_bit
        localparam int SH = LAST - j;
        logic [rpc_pkg::R_W-1:0] trial;
        logic                    hit;

        assign trial = rpc_pkg::R_W'(den_reg[j-1]) << SH;
        assign hit   = rem_reg[j-1] >= trial;

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                sat_reg[j] <= sat_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | (hit ? (8'd1 << SH) : 8'd0);
            end
        end

        if (j < LAST)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    rem_reg[j] <= hit ? (rem_reg[j-1] - trial) : rem_reg[j-1];
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end
    end

    assign quo = sat_reg[LAST] ? 8'hFF : q_reg[LAST];

endmodule

`default_nettype wire

FILE: hw/rtl/rgba_pixel_compositor_core.sv
// Top level of the RGBA pixel compositor: operand pipeline and four divider lanes.
`default_nettype none

// The compositor takes one destination and one source RGBA pixel per word and returns
// the pixel composited under the operator held in blend_mode: the Porter-Duff style
// operators copy through xor (codes 0 to 10) and the separable blend modes multiply
// through exclusion (codes 11 to 21); any other code behaves as copy. Every channel is
// the exact rational value of its formula, truncated and clamped to 0..255. The block
// accepts a new word in every clock cycle in which in_stall is low. Six stages build
// a numerator and a denominator for each of the four channels (alpha products, blend
// terms with the soft-light root table, the linear sum, the wide products and their
// sum); nine more stages hold a restoring divider per channel that settles one
// quotient bit a stage. Each stage carries a valid bit and advances whenever the stage
// after it can take its word, so bubbles close up and a stalled output holds its word
// while earlier stages keep filling. blend_mode is sampled with each input word and
// should be written only while the block is empty.
module rgba_pixel_compositor_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [4:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] dest_red,
    input  logic [7:0] dest_green,
    input  logic [7:0] dest_blue,
    input  logic [7:0] dest_alpha,
    input  logic [7:0] src_red,
    input  logic [7:0] src_green,
    input  logic [7:0] src_blue,
    input  logic [7:0] src_alpha,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha
);

    localparam int NS = rpc_pkg::PIPE_STAGES;
    localparam int DF = rpc_pkg::DIV_FIRST;

    // Blend function of one channel, returned as {denominator, numerator}.
    function automatic logic [41:0] blend_term(
        input rpc_pkg::mode_t mode,
        input logic [7:0]     d,
        input logic [7:0]     s,
        input logic [15:0]    ds,
        input logic [15:0]    inv,
        input logic [16:0]    hp,
        input logic [16:0]    slp,
        input logic [15:0]    tab
    );
        logic [24:0] bn;
        logic [16:0] bq;
        logic [17:0] lo_sum;
        logic [25:0] lo;
        logic [24:0] hi;
        logic [8:0]  sum9;
        lo_sum = {1'b0, s, 9'b0} + 18'(slp);
        lo     = 26'(d) * 26'(lo_sum);
        hi     = {slp, 8'b0} + 25'(tab) * 25'({s[6:0], 1'b1});
        sum9   = {1'b0, d} + {1'b0, s};
        bn     = '0;
        bq     = 17'd1;
        unique case (mode)
            rpc_pkg::MODE_MULTIPLY:
            begin
                bn = 25'(ds);
                bq = 17'd255;
            end
            rpc_pkg::MODE_SCREEN:
            begin
                bn = 25'(16'd65025 - inv);
                bq = 17'd255;
            end
            rpc_pkg::MODE_OVERLAY:
            begin
                bn = d[7] ? 25'(17'd65025 - {inv, 1'b0}) : 25'({ds, 1'b0});
                bq = 17'd255;
            end
            rpc_pkg::MODE_DARKEN:
            begin
                bn = 25'((d < s) ? d : s);
            end
            rpc_pkg::MODE_LIGHTEN:
            begin
                bn = 25'((d > s) ? d : s);
            end
            rpc_pkg::MODE_COLOR_DODGE:
            begin
                if (sum9[8])
                begin
                    bn = 25'd255;
                end
                else
                begin
                    bn = 25'(16'(d) * 16'd255);
                    bq = 17'(9'd256 - {1'b0, s});
                end
            end
            rpc_pkg::MODE_COLOR_BURN:
            begin
                if (sum9 >= 9'd254)
                begin
                    bn = 25'(17'(sum9 - 9'd254) * 17'd255);
                    bq = 17'(s) + 17'd1;
                end
            end
            rpc_pkg::MODE_HARD_LIGHT:
            begin
                if (s > 8'd128)
                begin
                    bn = 25'(17'd65025 - hp);
                    bq = 17'd255;
                end
                else
                begin
                    bn = 25'(ds);
                    bq = 17'd128;
                end
            end
            rpc_pkg::MODE_SOFT_LIGHT:
            begin
                bn = s[7] ? hi : lo[24:0];
                bq = 17'd65536;
            end
            rpc_pkg::MODE_DIFFERENCE:
            begin
                bn = 25'((d > s) ? (d - s) : (s - d));
            end
            rpc_pkg::MODE_EXCLUSION:
            begin
                bn = 25'(17'(sum9) * 17'd255 - {ds, 1'b0});
                bq = 17'd255;
            end
            default:
            begin
                bn = '0;
                bq = 17'd1;
            end
        endcase
        return {bq, bn};
    endfunction

    // ---------------- Stage valids and advance enables ----------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[NS-1];

    // ---------------- Configuration register ----------------
    logic [4:0] blend_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            blend_mode_reg <= cfg_wr_data;
        end
    end

    // ---------------- Stage 0: capture pixels and operator ----------------
    logic [7:0]     s0_dc_reg [3];
    logic [7:0]     s0_sc_reg [3];
    logic [7:0]     s0_da_reg;
    logic [7:0]     s0_sa_reg;
    rpc_pkg::mode_t s0_mode_reg;
    rpc_pkg::mode_t s0_mode_next;

    assign s0_mode_next = (blend_mode_reg > 5'(rpc_pkg::MODE_EXCLUSION)) ?
                          rpc_pkg::MODE_COPY : rpc_pkg::mode_t'(blend_mode_reg);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_dc_reg[0] <= dest_red;
            s0_dc_reg[1] <= dest_green;
            s0_dc_reg[2] <= dest_blue;
            s0_sc_reg[0] <= src_red;
            s0_sc_reg[1] <= src_green;
            s0_sc_reg[2] <= src_blue;
            s0_da_reg    <= dest_alpha;
            s0_sa_reg    <= src_alpha;
            s0_mode_reg  <= s0_mode_next;
        end
    end

    // ---------------- Stage A: alpha and per-channel products ----------------
    logic [7:0]     a_dc_reg [3];
    logic [7:0]     a_sc_reg [3];
    logic [7:0]     a_da_reg;
    logic [7:0]     a_sa_reg;
    rpc_pkg::mode_t a_mode_reg;
    logic [15:0]    a_sada_reg;
    logic [15:0]    a_sa_ida_reg;
    logic [15:0]    a_da_isa_reg;
    logic [15:0]    a_sa255_reg;
    logic [15:0]    a_da255_reg;
    logic [15:0]    a_ds_reg  [3];
    logic [15:0]    a_inv_reg [3];
    logic [16:0]    a_hp_reg  [3];
    logic [16:0]    a_slp_reg [3];
    logic [15:0]    a_tab_reg [3];
    logic [8:0]     a_f_next  [3];

    always_comb
    begin
        // Soft light scales d by (255 - 2s) below mid-gray and by (511 - 2s) above it.
        for (int i = 0; i < 3; i++)
        begin
            a_f_next[i] = (s0_sc_reg[i][7] ? 9'd511 : 9'd255) - {s0_sc_reg[i], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            a_da_reg     <= s0_da_reg;
            a_sa_reg     <= s0_sa_reg;
            a_mode_reg   <= s0_mode_reg;
            a_sada_reg   <= 16'(s0_sa_reg) * 16'(s0_da_reg);
            a_sa_ida_reg <= 16'(s0_sa_reg) * 16'(8'd255 - s0_da_reg);
            a_da_isa_reg <= 16'(s0_da_reg) * 16'(8'd255 - s0_sa_reg);
            a_sa255_reg  <= {s0_sa_reg, 8'b0} - 16'(s0_sa_reg);
            a_da255_reg  <= {s0_da_reg, 8'b0} - 16'(s0_da_reg);
            for (int i = 0; i < 3; i++)
            begin
                a_dc_reg[i]  <= s0_dc_reg[i];
                a_sc_reg[i]  <= s0_sc_reg[i];
                a_ds_reg[i]  <= 16'(s0_dc_reg[i]) * 16'(s0_sc_reg[i]);
                a_inv_reg[i] <= 16'(8'd255 - s0_dc_reg[i]) * 16'(8'd255 - s0_sc_reg[i]);
                a_hp_reg[i]  <= 17'(9'd511 - {s0_sc_reg[i], 1'b0}) *
                                17'(8'd255 - s0_dc_reg[i]);
                a_slp_reg[i] <= 17'(s0_dc_reg[i]) * 17'(a_f_next[i]);
                a_tab_reg[i] <= rpc_pkg::SQRT_LUT[s0_dc_reg[i]];
            end
        end
    end

    // ---------------- Stage B: operator selection and weighted colors ----------------
    logic [15:0] b_p1;
    logic [15:0] b_p2;
    logic [15:0] b_kq_next;
    logic [15:0] b_alin_next;
    logic [7:0]  b_akq_next;
    logic        b_blend;
    logic [15:0] k_so;
    logic [15:0] k_do;
    logic [15:0] k_x;
    logic [8:0]  a_sum;
    logic [15:0] k_lt;
    logic [41:0] b_term [3];

    logic [23:0] b_cp_reg   [3];
    logic [23:0] b_dp_reg   [3];
    logic [24:0] b_bn_reg   [3];
    logic [16:0] b_bq_reg   [3];
    logic [15:0] b_kq_reg;
    logic [15:0] b_alin_reg;
    logic [7:0]  b_akq_reg;
    logic [15:0] b_sada_reg;

    always_comb
    begin
        k_so  = a_sa255_reg + a_da_isa_reg;
        k_do  = a_da255_reg + a_sa_ida_reg;
        k_x   = a_sa_ida_reg + a_da_isa_reg;
        a_sum = {1'b0, a_sa_reg} + {1'b0, a_da_reg};
        k_lt  = (a_sum >= 9'd255) ? 16'd255 : 16'(a_sum);

        // Defaults give the source pixel unchanged; the zero pixel sets every
        // numerator to zero with a unit divisor.
        b_p1        = 16'd1;
        b_p2        = 16'd0;
        b_kq_next   = 16'd1;
        b_alin_next = 16'(a_sa_reg);
        b_akq_next  = 8'd1;
        b_blend     = 1'b0;

        unique case (a_mode_reg)
            rpc_pkg::MODE_SRC_OVER:
            begin
                if (a_da_reg != 8'd0 && a_sa_reg != 8'd255)
                begin
                    b_p1        = a_sa255_reg;
                    b_p2        = a_da_isa_reg;
                    b_kq_next   = k_so;
                    b_alin_next = k_so;
                    b_akq_next  = 8'd255;
                end
            end
            rpc_pkg::MODE_SRC_IN, rpc_pkg::MODE_SRC_OUT, rpc_pkg::MODE_SRC_ATOP:
            begin
                if (a_da_reg == 8'd0)
                begin
                    b_p1        = 16'd0;
                    b_alin_next = 16'd0;
                end
                else if (a_mode_reg == rpc_pkg::MODE_SRC_IN)
                begin
                    b_alin_next = a_sada_reg;
                    b_akq_next  = 8'd255;
                end
                else if (a_mode_reg == rpc_pkg::MODE_SRC_OUT)
                begin
                    b_alin_next = a_sa_ida_reg;
                    b_akq_next  = 8'd255;
                end
                else
                begin
                    b_p1        = 16'(a_sa_reg);
                    b_p2        = 16'(8'd255 - a_sa_reg);
                    b_kq_next   = 16'd255;
                    b_alin_next = 16'(a_da_reg);
                end
            end
            rpc_pkg::MODE_DST_OVER:
            begin
                if (a_da_reg == 8'd255 || a_sa_reg == 8'd0)
                begin
                    b_p1        = 16'd0;
                    b_p2        = 16'd1;
                    b_alin_next = 16'(a_da_reg);
                end
                else
                begin
                    b_p1        = a_sa_ida_reg;
                    b_p2        = a_da255_reg;
                    b_kq_next   = k_do;
                    b_alin_next = k_do;
                    b_akq_next  = 8'd255;
                end
            end
            rpc_pkg::MODE_DST_IN, rpc_pkg::MODE_DST_ATOP:
            begin
                if (a_sa_reg == 8'd0)
                begin
                    b_p1        = 16'd0;
                    b_alin_next = 16'd0;
                end
                else if (a_mode_reg == rpc_pkg::MODE_DST_IN)
                begin
                    b_p1        = 16'd0;
                    b_p2        = 16'd1;
                    b_alin_next = a_sada_reg;
                    b_akq_next  = 8'd255;
                end
                else
                begin
                    b_p1      = 16'(8'd255 - a_da_reg);
                    b_p2      = 16'(a_da_reg);
                    b_kq_next = 16'd255;
                end
            end
            rpc_pkg::MODE_DST_OUT:
            begin
                b_p1        = 16'd0;
                b_p2        = (a_sa_reg == 8'd255) ? 16'd0 : 16'd1;
                b_alin_next = a_da_isa_reg;
                b_akq_next  = 8'd255;
            end
            rpc_pkg::MODE_LIGHTER:
            begin
                if (a_sum == 9'd0)
                begin
                    b_p1        = 16'd0;
                    b_alin_next = 16'd0;
                end
                else
                begin
                    b_p1        = 16'(a_sa_reg);
                    b_p2        = 16'(a_da_reg);
                    b_kq_next   = k_lt;
                    b_alin_next = k_lt;
                end
            end
            rpc_pkg::MODE_XOR:
            begin
                if (k_x == 16'd0)
                begin
                    b_p1        = 16'd0;
                    b_alin_next = 16'd0;
                end
                else
                begin
                    b_p1        = a_sa_ida_reg;
                    b_p2        = a_da_isa_reg;
                    b_kq_next   = k_x;
                    b_alin_next = k_x;
                    b_akq_next  = 8'd255;
                end
            end
            rpc_pkg::MODE_MULTIPLY, rpc_pkg::MODE_SCREEN, rpc_pkg::MODE_OVERLAY,
            rpc_pkg::MODE_DARKEN, rpc_pkg::MODE_LIGHTEN, rpc_pkg::MODE_COLOR_DODGE,
            rpc_pkg::MODE_COLOR_BURN, rpc_pkg::MODE_HARD_LIGHT, rpc_pkg::MODE_SOFT_LIGHT,
            rpc_pkg::MODE_DIFFERENCE, rpc_pkg::MODE_EXCLUSION:
            begin
                // Both alphas zero leave nothing to blend: the result is all zero.
                if (k_so == 16'd0)
                begin
                    b_p1        = 16'd0;
                    b_alin_next = 16'd0;
                end
                else
                begin
                    b_p1        = a_sa_ida_reg;
                    b_p2        = a_da_isa_reg;
                    b_kq_next   = k_so;
                    b_alin_next = k_so;
                    b_akq_next  = 8'd255;
                    b_blend     = 1'b1;
                end
            end
            default:
            begin
                b_p1 = 16'd1;
            end
        endcase

        for (int i = 0; i < 3; i++)
        begin
            b_term[i] = blend_term(a_mode_reg, a_dc_reg[i], a_sc_reg[i], a_ds_reg[i],
                                   a_inv_reg[i], a_hp_reg[i], a_slp_reg[i], a_tab_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                b_cp_reg[i] <= 24'(a_sc_reg[i]) * 24'(b_p1);
                b_dp_reg[i] <= 24'(a_dc_reg[i]) * 24'(b_p2);
                b_bn_reg[i] <= b_blend ? b_term[i][24:0] : 25'd0;
                b_bq_reg[i] <= b_blend ? b_term[i][41:25] : 17'd1;
            end
            b_kq_reg   <= b_kq_next;
            b_alin_reg <= b_alin_next;
            b_akq_reg  <= b_akq_next;
            b_sada_reg <= a_sada_reg;
        end
    end

    // ---------------- Stage C: linear sums, one lane per channel ----------------
    logic [24:0] c_lin_reg [rpc_pkg::LANES];
    logic [15:0] c_kq_reg  [rpc_pkg::LANES];
    logic [16:0] c_bq_reg  [rpc_pkg::LANES];
    logic [24:0] c_bn_reg  [rpc_pkg::LANES];
    logic [15:0] c_sada_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_lin_reg[i] <= 25'(b_cp_reg[i]) + 25'(b_dp_reg[i]);
                c_kq_reg[i]  <= b_kq_reg;
                c_bq_reg[i]  <= b_bq_reg[i];
                c_bn_reg[i]  <= b_bn_reg[i];
            end
            c_lin_reg[3] <= 25'(b_alin_reg);
            c_kq_reg[3]  <= 16'(b_akq_reg);
            c_bq_reg[3]  <= 17'd1;
            c_bn_reg[3]  <= 25'd0;
            c_sada_reg   <= b_sada_reg;
        end
    end

    // ---------------- Stage D: scale by the blend divisor ----------------
    logic [41:0]             d_p1_reg [rpc_pkg::LANES];
    logic [40:0]             d_p2_reg [rpc_pkg::LANES];
    logic [rpc_pkg::Q_W-1:0] d_q_reg  [rpc_pkg::LANES];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < rpc_pkg::LANES; i++)
            begin
                d_p1_reg[i] <= 42'(c_lin_reg[i]) * 42'(c_bq_reg[i]);
                d_p2_reg[i] <= 41'(c_sada_reg) * 41'(c_bn_reg[i]);
                d_q_reg[i]  <= rpc_pkg::Q_W'(c_kq_reg[i]) * rpc_pkg::Q_W'(c_bq_reg[i]);
            end
        end
    end

    // ---------------- Stage E: final numerator ----------------
    logic [rpc_pkg::N_W-1:0] e_n_reg [rpc_pkg::LANES];
    logic [rpc_pkg::Q_W-1:0] e_q_reg [rpc_pkg::LANES];

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int i = 0; i < rpc_pkg::LANES; i++)
            begin
                e_n_reg[i] <= rpc_pkg::N_W'(d_p1_reg[i]) + rpc_pkg::N_W'(d_p2_reg[i]);
                e_q_reg[i] <= d_q_reg[i];
            end
        end
    end

    // ---------------- Divider lanes ----------------
    logic [7:0] quo [rpc_pkg::LANES];

    for (genvar g = 0; g < rpc_pkg::LANES; g++)
    begin : g_lane
        rpc_div u_div (
            .clk (clk),
            .en  (en[NS-1:DF]),
            .num (e_n_reg[g]),
            .den (e_q_reg[g]),
            .quo (quo[g])
        );
    end

    assign out_red   = quo[0];
    assign out_green = quo[1];
    assign out_blue  = quo[2];
    assign out_alpha = quo[3];

endmodule

`default_nettype wire

FILE: hw/rtl/rpc_checker.sv
// Port-level checks of the pixel compositor and their binding to the top level.
`default_nettype none

module rpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue,
    input logic [7:0] out_alpha
);

    // A waiting result word stays and keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
            && $stable(out_blue) && $stable(out_alpha))
        else $error("stalled result word changed");

    // With the output stage empty every stage can advance, so input is never held off.
    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output stage empty");

    // Input is held off only behind a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result word present after reset");

endmodule

bind rgba_pixel_compositor_core rpc_checker u_rpc_checker (.*);

`default_nettype wire

FILE: bench/rgba_pixel_compositor_core_tb.sv
// Self-checking testbench for the RGBA pixel compositor across all operators.
`timescale 1ns / 1ps

module rgba_pixel_compositor_core_tb;

    localparam int RANDOM_WORDS = 1800;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] dr, dg, db, da, sr, sg, sb, sa;
    } pair_t;

    typedef struct packed {
        logic [7:0] r, g, b, a;
    } pixel_t;

    // One directed row: the pixel pair, the operator, and an optional typed-in result.
    typedef struct {
        rpc_pkg::mode_t op;
        pair_t          pair;
        logic           has_known;
        pixel_t         known;
    } vector_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [4:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] dest_red = '0, dest_green = '0, dest_blue = '0, dest_alpha = '0;
    logic [7:0] src_red = '0, src_green = '0, src_blue = '0, src_alpha = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] out_red, out_green, out_blue, out_alpha;

    always #2 clk = ~clk;

    rgba_pixel_compositor_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .dest_red   (dest_red),
        .dest_green (dest_green),
        .dest_blue  (dest_blue),
        .dest_alpha (dest_alpha),
        .src_red    (src_red),
        .src_green  (src_green),
        .src_blue   (src_blue),
        .src_alpha  (src_alpha),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha)
    );

    // The operator the predictor believes the block holds.
    logic [4:0] active_mode;
    pixel_t expected_pixels[$];
    int mismatches = 0;
    int words_checked = 0;
    int modes_covered = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;
    // In the final stretch neither side inserts bubbles or stalls.
    bit quiet_tail = 1'b0;

    // Floor of n/q clamped to a channel, zero for nonpositive numerators.
    function automatic logic [7:0] clamp_quotient(longint n, longint q);
        longint v;
        if (n <= 0 || q <= 0)
            return 8'd0;
        v = n / q;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // Integer root of d * 2^24, the soft-light table entry for destination value d.
    function automatic longint root_entry(longint d);
        longint x;
        longint res;
        longint b;
        x = d << 24;
        res = 0;
        b = longint'(1) << 40;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Separable blend function of destination d and source s as a fraction num/den.
    function automatic void blend_term(rpc_pkg::mode_t op, longint d, longint s,
                                       output longint num, output longint den);
        den = 1;
        case (op)
            rpc_pkg::MODE_MULTIPLY:
            begin
                num = d * s;
                den = 255;
            end
            rpc_pkg::MODE_SCREEN:
            begin
                num = 65025 - (255 - d) * (255 - s);
                den = 255;
            end
            rpc_pkg::MODE_OVERLAY:
            begin
                num = (d < 128) ? 2 * s * d : 65025 - 2 * (255 - s) * (255 - d);
                den = 255;
            end
            rpc_pkg::MODE_DARKEN: num = (d < s) ? d : s;
            rpc_pkg::MODE_LIGHTEN: num = (d > s) ? d : s;
            rpc_pkg::MODE_COLOR_DODGE:
            begin
                if (d >= 256 - s)
                    num = 255;
                else
                begin
                    num = 255 * d;
                    den = 256 - s;
                end
            end
            rpc_pkg::MODE_COLOR_BURN:
            begin
                num = 255 * (s + 1) - 255 * (255 - d);
                den = s + 1;
                if (num < 0)
                begin
                    num = 0;
                    den = 1;
                end
            end
            rpc_pkg::MODE_HARD_LIGHT:
            begin
                if (s > 128)
                begin
                    num = 65025 - (511 - 2 * s) * (255 - d);
                    den = 255;
                end
                else
                begin
                    num = d * s;
                    den = 128;
                end
            end
            rpc_pkg::MODE_SOFT_LIGHT:
            begin
                if (s < 128)
                    num = d * (512 * s + d * (255 - 2 * s));
                else
                    num = 256 * d * (511 - 2 * s) + root_entry(d) * (2 * s - 255);
                den = 65536;
            end
            rpc_pkg::MODE_DIFFERENCE: num = (d > s) ? d - s : s - d;
            default:
            begin
                num = 255 * (d + s) - 2 * d * s;
                den = 255;
            end
        endcase
    endfunction

    // Composites one pixel pair under the given operator code.
    function automatic pixel_t composite(logic [4:0] code, pair_t p);
        longint dc[3];
        longint sc[3];
        longint da, sa, k, bn, bq, lin;
        logic [7:0] ch[4];
        rpc_pkg::mode_t op;
        pixel_t px;
        da = longint'(p.da);
        sa = longint'(p.sa);
        dc[0] = longint'(p.dr); dc[1] = longint'(p.dg); dc[2] = longint'(p.db);
        sc[0] = longint'(p.sr); sc[1] = longint'(p.sg); sc[2] = longint'(p.sb);
        for (int i = 0; i < 3; i++)
            ch[i] = sc[i][7:0];
        ch[3] = sa[7:0];
        // Codes past the last operator fall back to a plain copy of the source.
        op = (code > rpc_pkg::MODE_EXCLUSION) ? rpc_pkg::MODE_COPY : rpc_pkg::mode_t'(code);
        case (op)
            rpc_pkg::MODE_COPY: ;
            rpc_pkg::MODE_SRC_OVER:
            begin
                if (!(da == 0 || sa == 255))
                begin
                    k = 255 * sa + da * (255 - sa);
                    for (int i = 0; i < 3; i++)
                        ch[i] = clamp_quotient(sc[i] * sa * 255 + dc[i] * da * (255 - sa), k);
                    ch[3] = clamp_quotient(k, 255);
                end
            end
            rpc_pkg::MODE_SRC_IN, rpc_pkg::MODE_SRC_OUT, rpc_pkg::MODE_SRC_ATOP:
            begin
                if (da == 0)
                    ch = '{8'd0, 8'd0, 8'd0, 8'd0};
                else if (op == rpc_pkg::MODE_SRC_IN)
                    ch[3] = clamp_quotient(da * sa, 255);
                else if (op == rpc_pkg::MODE_SRC_OUT)
                    ch[3] = clamp_quotient(sa * (255 - da), 255);
                else
                begin
                    for (int i = 0; i < 3; i++)
                        ch[i] = clamp_quotient(sc[i] * sa + dc[i] * (255 - sa), 255);
                    ch[3] = da[7:0];
                end
            end
            rpc_pkg::MODE_DST_OVER:
            begin
                for (int i = 0; i < 3; i++)
                    ch[i] = dc[i][7:0];
                ch[3] = da[7:0];
                if (!(da == 255 || sa == 0))
                begin
                    k = 255 * da + sa * (255 - da);
                    for (int i = 0; i < 3; i++)
                        ch[i] = clamp_quotient(sc[i] * sa * (255 - da) + dc[i] * da * 255, k);
                    ch[3] = clamp_quotient(k, 255);
                end
            end
            rpc_pkg::MODE_DST_IN, rpc_pkg::MODE_DST_ATOP:
            begin
                if (sa == 0)
                    ch = '{8'd0, 8'd0, 8'd0, 8'd0};
                else if (op == rpc_pkg::MODE_DST_IN)
                begin
                    for (int i = 0; i < 3; i++)
                        ch[i] = dc[i][7:0];
                    ch[3] = clamp_quotient(da * sa, 255);
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        ch[i] = clamp_quotient(sc[i] * (255 - da) + dc[i] * da, 255);
                    ch[3] = sa[7:0];
                end
            end
            rpc_pkg::MODE_DST_OUT:
            begin
                // An opaque source wipes the destination colors.
                for (int i = 0; i < 3; i++)
                    ch[i] = (sa == 255) ? 8'd0 : dc[i][7:0];
                ch[3] = clamp_quotient(da * (255 - sa), 255);
            end
            rpc_pkg::MODE_LIGHTER:
            begin
                if (da == 0 && sa == 0)
                    ch = '{8'd0, 8'd0, 8'd0, 8'd0};
                else
                begin
                    k = (sa + da >= 255) ? 255 : sa + da;
                    for (int i = 0; i < 3; i++)
                        ch[i] = clamp_quotient(sc[i] * sa + dc[i] * da, k);
                    ch[3] = k[7:0];
                end
            end
            rpc_pkg::MODE_XOR:
            begin
                k = sa * (255 - da) + da * (255 - sa);
                if (k == 0)
                    ch = '{8'd0, 8'd0, 8'd0, 8'd0};
                else
                begin
                    for (int i = 0; i < 3; i++)
                        ch[i] = clamp_quotient(sc[i] * sa * (255 - da)
                                               + dc[i] * da * (255 - sa), k);
                    ch[3] = clamp_quotient(k, 255);
                end
            end
            default:
            begin
                k = 255 * sa + da * (255 - sa);
                if (k == 0)
                    ch = '{8'd0, 8'd0, 8'd0, 8'd0};
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        blend_term(op, dc[i], sc[i], bn, bq);
                        lin = sa * (255 - da) * sc[i] + da * (255 - sa) * dc[i];
                        ch[i] = clamp_quotient(lin * bq + sa * da * bn, k * bq);
                    end
                    ch[3] = clamp_quotient(k, 255);
                end
            end
        endcase
        px.r = ch[0];
        px.g = ch[1];
        px.b = ch[2];
        px.a = ch[3];
        return px;
    endfunction

    // Outputs are sampled on the rising edge; anything the block returns while the
    // stall is low is compared with the oldest pending expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            pixel_t got;
            pixel_t want;
            got = {out_red, out_green, out_blue, out_alpha};
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word r=%0d g=%0d b=%0d a=%0d", $time,
                         got.r, got.g, got.b, got.a);
            end
            else
            begin
                want = expected_pixels.pop_front();
                words_checked++;
                if (got.r !== want.r)
                    $display("%0t: red expected %0d actual %0d", $time, want.r, got.r);
                if (got.g !== want.g)
                    $display("%0t: green expected %0d actual %0d", $time, want.g, got.g);
                if (got.b !== want.b)
                    $display("%0t: blue expected %0d actual %0d", $time, want.b, got.b);
                if (got.a !== want.a)
                    $display("%0t: alpha expected %0d actual %0d", $time, want.a, got.a);
                if (got !== want)
                    mismatches++;
            end
        end
    end

    // The receiver stalls in random bursts, and never during the quiet tail.
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (quiet_tail)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog: counts cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d words outstanding", expected_pixels.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Writes the operator register; only called with the pipeline empty.
    task automatic write_mode(logic [4:0] code);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= code;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        active_mode = code;
        modes_covered++;
        @(posedge clk);
    endtask

    // Presents one pixel pair and holds it until the block accepts it. An optional
    // idle gap of random length is inserted first, outside the quiet tail.
    task automatic send_pair(pair_t p, bit known_valid, pixel_t known);
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        {dest_red, dest_green, dest_blue, dest_alpha} <= {p.dr, p.dg, p.db, p.da};
        {src_red, src_green, src_blue, src_alpha} <= {p.sr, p.sg, p.sb, p.sa};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_pixels.push_back(known_valid ? known : composite(active_mode, p));
    endtask

    // Drops valid and waits for every outstanding word, then lets the pipeline idle before returning.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic pair_t random_pair();
        pair_t p;
        p = pair_t'({$urandom, $urandom});
        // Alphas often sit at the edges, where most early-outs live.
        case ($urandom_range(0, 5))
            0: p.da = 8'd0;
            1: p.da = 8'd255;
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: p.sa = 8'd0;
            1: p.sa = 8'd255;
            default: ;
        endcase
        return p;
    endfunction

    vector_row_t directed[] = '{
        // Copy out of reset returns the source unchanged.
        '{rpc_pkg::MODE_COPY, 64'h0000_0000_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{rpc_pkg::MODE_COPY, 64'hFFFF_FFFF_0000_0000, 1'b1, 32'h0000_0000},
        // Source over with a transparent destination yields the source.
        '{rpc_pkg::MODE_SRC_OVER, 64'h1122_3300_4455_6680, 1'b1, 32'h4455_6680},
        '{rpc_pkg::MODE_SRC_OVER, 64'h1122_33FF_4455_6680, 1'b0, '0},
        // Source in, out and atop give zero on a transparent destination.
        '{rpc_pkg::MODE_SRC_IN, 64'h1122_3300_4455_66FF, 1'b1, 32'h0},
        '{rpc_pkg::MODE_SRC_OUT, 64'h1122_3300_4455_66FF, 1'b1, 32'h0},
        '{rpc_pkg::MODE_SRC_ATOP, 64'h1122_3300_4455_66FF, 1'b1, 32'h0},
        '{rpc_pkg::MODE_SRC_ATOP, 64'h1122_3380_4455_6640, 1'b0, '0},
        '{rpc_pkg::MODE_DST_OVER, 64'h1122_33FF_4455_6680, 1'b1, 32'h1122_33FF},
        '{rpc_pkg::MODE_DST_OVER, 64'h1122_3340_4455_6680, 1'b0, '0},
        // Destination in and atop give zero on a transparent source.
        '{rpc_pkg::MODE_DST_IN, 64'h1122_33FF_4455_6600, 1'b1, 32'h0},
        '{rpc_pkg::MODE_DST_ATOP, 64'h1122_33FF_4455_6600, 1'b1, 32'h0},
        // An opaque source clears destination out entirely.
        '{rpc_pkg::MODE_DST_OUT, 64'h1122_33FF_4455_66FF, 1'b1, 32'h0},
        '{rpc_pkg::MODE_LIGHTER, 64'hFFFF_FF00_FFFF_FF00, 1'b1, 32'h0},
        '{rpc_pkg::MODE_LIGHTER, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{rpc_pkg::MODE_XOR, 64'h1122_33FF_4455_66FF, 1'b1, 32'h0},
        '{rpc_pkg::MODE_XOR, 64'h1122_3380_4455_6640, 1'b0, '0},
        // Blend modes with both alphas zero have nothing to divide by.
        '{rpc_pkg::MODE_MULTIPLY, 64'hFFFF_FF00_FFFF_FF00, 1'b1, 32'h0},
        '{rpc_pkg::MODE_SCREEN, 64'h80C0_4090_2060_E070, 1'b0, '0},
        '{rpc_pkg::MODE_OVERLAY, 64'h7F80_FF90_0080_FF70, 1'b0, '0},
        '{rpc_pkg::MODE_DARKEN, 64'h7F80_FFA0_0080_FF70, 1'b0, '0},
        '{rpc_pkg::MODE_LIGHTEN, 64'h7F80_FFA0_0080_FF70, 1'b0, '0},
        '{rpc_pkg::MODE_COLOR_DODGE, 64'hFF01_80C0_FF00_7FC0, 1'b0, '0},
        '{rpc_pkg::MODE_COLOR_BURN, 64'h0001_80C0_FF00_7FC0, 1'b0, '0},
        '{rpc_pkg::MODE_HARD_LIGHT, 64'h8040_FFC0_8081_FFC0, 1'b0, '0},
        '{rpc_pkg::MODE_SOFT_LIGHT, 64'hFF40_01C0_7F80_FFC0, 1'b0, '0},
        '{rpc_pkg::MODE_DIFFERENCE, 64'h00FF_80C0_FF00_81C0, 1'b0, '0},
        '{rpc_pkg::MODE_EXCLUSION, 64'h00FF_80C0_FF00_81C0, 1'b0, '0}
    };

    initial
    begin
        int sent;
        active_mode = rpc_pkg::MODE_COPY;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the operator is written for the first row and rewritten only when a row asks for a new one.
        foreach (directed[i])
        begin
            if (i == 0 || directed[i].op != rpc_pkg::mode_t'(active_mode))
            begin
                drain_pipeline();
                write_mode(directed[i].op);
            end
            send_pair(directed[i].pair, directed[i].has_known, directed[i].known);
        end

        // Random part: phases under random operators, with the extremes and an
        // unknown code among them; codes past exclusion must behave as copy.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            logic [4:0] code;
            int span;
            drain_pipeline();
            case (modes_covered % 6)
                0: code = 5'd31;
                1: code = rpc_pkg::MODE_EXCLUSION;
                default: code = $urandom_range(0, 23) == 23 ?
                                5'($urandom_range(22, 31)) : 5'($urandom_range(0, 21));
            endcase
            write_mode(code);
            span = $urandom_range(20, 60);
            if (sent + span > RANDOM_WORDS - 150)
                quiet_tail = 1'b1;
            for (int n = 0; n < span; n++)
                send_pair(random_pair(), 1'b0, '0);
            sent += span;
        end

        drain_pipeline();
        $display("%0d words checked across %0d operator settings, %0d of them random",
                 words_checked, modes_covered, sent);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
